@@ src/g3rld_pkg.sv @@
// ----------------------------------------------------------------------------
// g3rld_pkg
// shared types, constants and code tables of the g3 run length decoder
// ----------------------------------------------------------------------------
`default_nettype none
package g3rld_pkg;

  localparam int MaxLinePelsDef  = 4096;
  localparam int RowCountBitsDef = 16;
  localparam int ColW            = 13;
  localparam int RunW            = 12;
  localparam int RowOutW         = 16;
  localparam int CodeW           = 14;
  localparam int LongestCode     = 13;
  localparam int LookaheadBits   = 20;

  localparam logic [1:0] EV_RUN  = 2'd0;
  localparam logic [1:0] EV_EOL  = 2'd1;
  localparam logic [1:0] EV_BAD  = 2'd2;
  localparam logic [1:0] EV_PAGE = 2'd3;

  localparam logic [1:0] PH_CODE     = 2'd0;
  localparam logic [1:0] PH_SEEK     = 2'd1;
  localparam logic [1:0] PH_FILL_EOL = 2'd2;
  localparam logic [1:0] PH_FILL_BAD = 2'd3;

  localparam logic [CodeW-1:0] EOL_MARK = 14'h100;

  typedef struct packed {
    logic             hit;
    logic [RunW-1:0]  run;
    logic             term;
  } code_hit_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic                color;
    logic [RunW-1:0]     len;
    logic [ColW-1:0]     col;
    logic [RowOutW-1:0]  rows;
    logic [ColW-1:0]     widest;
  } event_t;

  typedef struct packed {
    logic load;
    logic step;
    logic push;
    logic push_last;
  } dp_cmd_t;

  typedef struct packed {
    logic blocked;
    logic emits;
    logic page;
  } dp_stat_t;

  localparam logic [CodeW-1:0] WHITE_TERM [64] = '{
    14'h135,14'h47,14'h17,14'h18,14'h1B,14'h1C,14'h1E,14'h1F,
    14'h33,14'h34,14'h27,14'h28,14'h48,14'h43,14'h74,14'h75,
    14'h6A,14'h6B,14'hA7,14'h8C,14'h88,14'h97,14'h83,14'h84,
    14'hA8,14'hAB,14'h93,14'hA4,14'h98,14'h102,14'h103,14'h11A,
    14'h11B,14'h112,14'h113,14'h114,14'h115,14'h116,14'h117,14'h128,
    14'h129,14'h12A,14'h12B,14'h12C,14'h12D,14'h104,14'h105,14'h10A,
    14'h10B,14'h152,14'h153,14'h154,14'h155,14'h124,14'h125,14'h158,
    14'h159,14'h15A,14'h15B,14'h14A,14'h14B,14'h132,14'h133,14'h134};

  localparam logic [CodeW-1:0] WHITE_MAKE [27] = '{
    14'h3B,14'h32,14'h57,14'hB7,14'h136,14'h137,14'h164,14'h165,14'h168,
    14'h167,14'h2CC,14'h2CD,14'h2D2,14'h2D3,14'h2D4,14'h2D5,14'h2D6,14'h2D7,
    14'h2D8,14'h2D9,14'h2DA,14'h2DB,14'h298,14'h299,14'h29A,14'h58,14'h29B};

  localparam logic [CodeW-1:0] BLACK_TERM [64] = '{
    14'h437,14'hA,14'h7,14'h6,14'hB,14'h13,14'h12,14'h23,
    14'h45,14'h44,14'h84,14'h85,14'h87,14'h104,14'h107,14'h218,
    14'h417,14'h418,14'h408,14'h867,14'h868,14'h86C,14'h837,14'h828,
    14'h817,14'h818,14'h10CA,14'h10CB,14'h10CC,14'h10CD,14'h1068,14'h1069,
    14'h106A,14'h106B,14'h10D2,14'h10D3,14'h10D4,14'h10D5,14'h10D6,14'h10D7,
    14'h106C,14'h106D,14'h10DA,14'h10DB,14'h1054,14'h1055,14'h1056,14'h1057,
    14'h1064,14'h1065,14'h1052,14'h1053,14'h1024,14'h1037,14'h1038,14'h1027,
    14'h1028,14'h1058,14'h1059,14'h102B,14'h102C,14'h105A,14'h1066,14'h1067};

  localparam logic [CodeW-1:0] BLACK_MAKE [27] = '{
    14'h40F,14'h10C8,14'h10C9,14'h105B,14'h1033,14'h1034,14'h1035,14'h206C,
    14'h206D,14'h204A,14'h204B,14'h204C,14'h204D,14'h2072,14'h2073,14'h2074,
    14'h2075,14'h2076,14'h2077,14'h2052,14'h2053,14'h2054,14'h2055,14'h205A,
    14'h205B,14'h2064,14'h2065};

  localparam logic [CodeW-1:0] EXT_MAKE [13] = '{
    14'h808,14'h80C,14'h80D,14'h1012,14'h1013,14'h1014,14'h1015,14'h1016,
    14'h1017,14'h101C,14'h101D,14'h101E,14'h101F};

  function automatic code_hit_t code_lookup(input logic color, input logic [CodeW-1:0] acc);
    code_hit_t r;
    logic [CodeW-1:0] t;
    logic [CodeW-1:0] m;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      t = color ? BLACK_TERM[i] : WHITE_TERM[i];
      if (!r.hit && t == acc) begin
        r.hit  = 1'b1;
        r.run  = RunW'(i);
        r.term = 1'b1;
      end
    end
    for (int i = 0; i < 27; i++) begin
      m = color ? BLACK_MAKE[i] : WHITE_MAKE[i];
      if (!r.hit && m == acc) begin
        r.hit = 1'b1;
        r.run = RunW'(64 * (i + 1));
      end
    end
    for (int i = 0; i < 13; i++) begin
      if (!r.hit && EXT_MAKE[i] == acc) begin
        r.hit = 1'b1;
        r.run = RunW'(1792 + 64 * i);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/g3rld_if.sv @@
// ----------------------------------------------------------------------------
// g3rld channel interfaces
// valid/ready channels for input bytes and decoded events
// ----------------------------------------------------------------------------
`default_nettype none
interface g3rld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] input_byte;
  modport source (output valid, output input_byte, input ready);
  modport sink (input valid, input input_byte, output ready);
endinterface

interface g3rld_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic        run_color;
  logic [11:0] run_length;
  logic [12:0] column_after;
  logic [15:0] row_index;
  logic [12:0] widest_line;
  logic        last_event;
  modport source (output valid, output event_kind, output run_color, output run_length,
                  output column_after, output row_index, output widest_line,
                  output last_event, input ready);
  modport sink (input valid, input event_kind, input run_color, input run_length,
                input column_after, input row_index, input widest_line,
                input last_event, output ready);
endinterface
`default_nettype wire

@@ src/fax_g3_run_length_decoder_core.sv @@
// each byte is taken in idle, then one decode step per code, per failed match,
// per skipped bit and per seek bit, a step that finds the byte used up and
// a flush that queues its last event; at most four events are decoded per
// byte taken, and steps that would give an event wait while the output stalls
// the single step unit gives one code or bit a cycle unless the output stalls
// reset: synchronous active-low, restores register defaults and decoder state
// ----------------------------------------------------------------------------
// fax_g3_run_length_decoder_core
// modified huffman g3 one-dimensional run decoder with apb configuration
// ----------------------------------------------------------------------------
`default_nettype none
module fax_g3_run_length_decoder_core #(
  parameter int MAX_LINE_PELS  = g3rld_pkg::MaxLinePelsDef,
  parameter int ROW_COUNT_BITS = g3rld_pkg::RowCountBitsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  g3rld_in_if.sink         in_ch,
  g3rld_out_if.source      out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import g3rld_pkg::*;

  logic [ColW-1:0] line_width_r;
  logic            bit_order_r;
  dp_cmd_t         cmd;
  dp_stat_t        stat;
  event_t          ev;
  logic            ev_last;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= ColW'(1728);
      bit_order_r <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) bit_order_r <= pwdata[0];
      else line_width_r <= pwdata[ColW-1:0];
    end
  end

  assign prdata = paddr[2] ? {31'd0, bit_order_r} : {19'd0, line_width_r};

  g3rld_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  g3rld_dp #(
    .MAX_LINE_PELS  (MAX_LINE_PELS),
    .ROW_COUNT_BITS (ROW_COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_byte    (in_ch.input_byte),
    .line_width (line_width_r),
    .bit_order  (bit_order_r),
    .out_ev     (ev),
    .out_last   (ev_last)
  );

  assign out_ch.event_kind   = ev.kind;
  assign out_ch.run_color    = ev.color;
  assign out_ch.run_length   = ev.len;
  assign out_ch.column_after = ev.col;
  assign out_ch.row_index    = ev.rows;
  assign out_ch.widest_line  = ev.widest;
  assign out_ch.last_event   = ev_last;

endmodule
`default_nettype wire

@@ src/g3rld_dp.sv @@
// ----------------------------------------------------------------------------
// g3rld_dp
// bit window, code match, line state and event registers
// ----------------------------------------------------------------------------
`default_nettype none
module g3rld_dp #(
  parameter int MAX_LINE_PELS  = g3rld_pkg::MaxLinePelsDef,
  parameter int ROW_COUNT_BITS = g3rld_pkg::RowCountBitsDef
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire g3rld_pkg::dp_cmd_t         cmd,
  output g3rld_pkg::dp_stat_t             stat,
  input  wire logic [7:0]                 in_byte,
  input  wire logic [g3rld_pkg::ColW-1:0] line_width,
  input  wire logic                       bit_order,
  output g3rld_pkg::event_t               out_ev,
  output logic                            out_last
);
  import g3rld_pkg::*;

  localparam logic [ROW_COUNT_BITS-1:0] RowMax = '1;

  logic [31:0]               win_r, win_nxt;
  logic [5:0]                held_r, held_nxt;
  logic                      color_r, color_nxt;
  logic [ColW-1:0]           column_r, column_nxt;
  logic [ROW_COUNT_BITS-1:0] rows_r, rows_nxt;
  logic [ColW-1:0]           widest_r, widest_nxt;
  logic [2:0]                empty_r, empty_nxt;
  logic [1:0]                phase_r, phase_nxt;
  logic                      page_r, page_nxt;
  event_t                    pend_r, out_r, ev_nxt;
  logic                      last_r;

  logic [7:0]       byte_ord;
  logic [5:0]       held_c;
  logic [CodeW-1:0] accs [LongestCode+1];
  code_hit_t        hits [LongestCode+1];
  logic             found, is_eol;
  logic [3:0]       code_len;
  code_hit_t        sel;
  logic [ColW-1:0]  eff_w, rem;
  logic [RunW-1:0]  n_run;
  logic             emits, blocked;
  logic             will_emit;
  logic [1:0]       kind;

  assign eff_w = (14'(line_width) > 14'(MAX_LINE_PELS)) ? ColW'(MAX_LINE_PELS) : line_width;

  always_comb begin
    for (int i = 0; i < 8; i++) byte_ord[i] = bit_order ? in_byte[7-i] : in_byte[i];
    held_c = (held_r > 6'd24) ? 6'd24 : held_r;
  end

  always_comb begin
    accs[0] = 14'd1;
    hits[0] = '0;
    for (int l = 1; l <= LongestCode; l++) begin
      accs[l] = {accs[l-1][CodeW-2:0], win_r[l-1]};
      hits[l] = code_lookup(color_r, accs[l]);
    end
    found = 1'b0;
    is_eol = 1'b0;
    code_len = '0;
    sel = '0;
    for (int l = 1; l <= LongestCode; l++) begin
      if (!found) begin
        if (l == 8 && accs[l] == EOL_MARK) begin
          found = 1'b1;
          is_eol = 1'b1;
          code_len = 4'(l);
        end else if (hits[l].hit) begin
          found = 1'b1;
          code_len = 4'(l);
          sel = hits[l];
        end
      end
    end
  end

  always_comb begin
    rem = eff_w - column_r;
    if (column_r >= eff_w) n_run = '0;
    else if (13'(sel.run) > rem) n_run = rem[RunW-1:0];
    else n_run = sel.run;
  end

  always_comb begin
    case (phase_r)
      PH_CODE: blocked = held_r < 6'(LookaheadBits);
      PH_SEEK: blocked = held_r < 6'd6;
      default: blocked = held_r == 6'd0;
    endcase
    blocked = blocked | page_r;
  end

  // whether the next step gives an event, independent of the step command
  always_comb begin
    case (phase_r)
      PH_CODE: will_emit = found && !is_eol;
      PH_SEEK: will_emit = 1'b0;
      default: will_emit = win_r[0];
    endcase
  end

  always_comb begin
    win_nxt = win_r;
    held_nxt = held_r;
    color_nxt = color_r;
    column_nxt = column_r;
    rows_nxt = rows_r;
    widest_nxt = widest_r;
    empty_nxt = empty_r;
    phase_nxt = phase_r;
    page_nxt = page_r;
    emits = 1'b0;
    kind = EV_RUN;
    ev_nxt = '0;
    if (cmd.load) begin
      win_nxt = win_r | (32'(byte_ord) << held_c);
      held_nxt = held_c + 6'd8;
    end else if (cmd.step) begin
      case (phase_r)
        PH_CODE: begin
          if (is_eol) begin
            win_nxt = win_r >> 8;
            held_nxt = held_r - 6'd8;
            phase_nxt = PH_FILL_EOL;
          end else if (found) begin
            win_nxt = win_r >> code_len;
            held_nxt = held_r - 6'(code_len);
            column_nxt = column_r + 13'(n_run);
            emits = 1'b1;
            ev_nxt.color = color_r;
            ev_nxt.len = n_run;
            if (sel.term) color_nxt = ~color_r;
          end else begin
            phase_nxt = PH_SEEK;
          end
        end
        PH_SEEK: begin
          if (win_r[5:0] == 6'd0) phase_nxt = PH_FILL_BAD;
          else begin
            win_nxt = win_r >> 1;
            held_nxt = held_r - 6'd1;
          end
        end
        default: begin
          win_nxt = win_r >> 1;
          held_nxt = held_r - 6'd1;
          if (win_r[0]) begin
            kind = (phase_r == PH_FILL_BAD) ? EV_BAD : EV_EOL;
            phase_nxt = PH_CODE;
            emits = 1'b1;
            color_nxt = 1'b0;
            if (column_r == '0) begin
              if (empty_r < 3'd7) empty_nxt = empty_r + 3'd1;
              if (empty_nxt >= 3'd4) begin
                page_nxt = 1'b1;
                kind = EV_PAGE;
              end
            end else begin
              if (column_r > widest_r && column_r <= eff_w) widest_nxt = column_r;
              if (rows_r < RowMax) rows_nxt = rows_r + 1'b1;
              column_nxt = '0;
              empty_nxt = '0;
            end
          end
        end
      endcase
    end
    ev_nxt.kind = kind;
    ev_nxt.col = column_nxt;
    ev_nxt.rows = RowOutW'(rows_nxt);
    ev_nxt.widest = widest_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      held_r <= '0;
      color_r <= 1'b0;
      column_r <= '0;
      rows_r <= '0;
      widest_r <= '0;
      empty_r <= '0;
      phase_r <= PH_CODE;
      page_r <= 1'b0;
    end else begin
      win_r <= win_nxt;
      held_r <= held_nxt;
      color_r <= color_nxt;
      column_r <= column_nxt;
      rows_r <= rows_nxt;
      widest_r <= widest_nxt;
      empty_r <= empty_nxt;
      phase_r <= phase_nxt;
      page_r <= page_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_r <= pend_r;
      last_r <= cmd.push_last;
    end
    if (cmd.step && emits) pend_r <= ev_nxt;
  end

  assign stat.blocked = blocked;
  assign stat.emits = will_emit;
  assign stat.page = page_r;
  assign out_ev = out_r;
  assign out_last = last_r;

endmodule
`default_nettype wire

@@ src/g3rld_ctrl.sv @@
// ----------------------------------------------------------------------------
// g3rld_ctrl
// sequencer: byte intake, decode steps and event beat hand-off
// ----------------------------------------------------------------------------
`default_nettype none
module g3rld_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output g3rld_pkg::dp_cmd_t       cmd,
  input  wire g3rld_pkg::dp_stat_t stat
);
  import g3rld_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pend_r, pend_nxt;
  logic       outv_r, outv_nxt;
  logic       out_free;

  assign out_free = !outv_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = outv_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    pend_nxt = pend_r;
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !stat.page) begin
          cmd.load = 1'b1;
          cnt_nxt = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat.blocked || cnt_r == 3'd4) begin
          state_nxt = pend_r ? ST_FLUSH : ST_IDLE;
        end else if (!(stat.emits && pend_r && !out_free)) begin
          cmd.step = 1'b1;
          if (stat.emits) begin
            cnt_nxt = cnt_r + 3'd1;
            cmd.push = pend_r;
            pend_nxt = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          cmd.push = 1'b1;
          cmd.push_last = 1'b1;
          pend_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    outv_nxt = cmd.push ? 1'b1 : (out_ready ? 1'b0 : outv_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      pend_r <= 1'b0;
      outv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      pend_r <= pend_nxt;
      outv_r <= outv_nxt;
    end
  end

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> out_free) else $error("event pushed over a waiting beat");
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4) else $error("too many events for one byte");
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pend_r) else $error("pending event left while idle");
  a_push_src: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> pend_r) else $error("push without pending event");

endmodule
`default_nettype wire
